[design/tsr_pkg.sv]
// shared types and constants for the triangle span rasterizer
package tsr_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_READY,
        ST_ADV0,
        ST_CHASE
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_LAST  = 2'd1,
        PH_UPPER = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        SRC_TOP    = 2'd0,
        SRC_FLAT   = 2'd1,
        SRC_BOTTOM = 2'd2
    } t_setup_src;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic       setup;
        t_setup_src src;
        logic       adv0;
        logic       adv1;
        logic       count;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic needs_split;
        logic flat_bottom;
        logic half_done;
        logic caught_up;
        logic chase_limit;
    } t_status;

endpackage

[design/tsr_ctrl.sv]
// control state machine of the triangle span rasterizer
module tsr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_action,
    input  tsr_pkg::t_status i_status,
    output tsr_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_strobe,
    output logic             o_final
);
    import tsr_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   acc_load, acc_step;

    assign acc_load = (r_state == ST_IDLE || r_state == ST_READY) && i_start && !i_action;
    assign acc_step = (r_state == ST_IDLE || r_state == ST_READY) && i_start && i_action;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_IDLE;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        case (r_state)
            ST_IDLE, ST_READY: begin
                if (acc_load) begin
                    n_state = ST_DIV;
                    n_phase = PH_IDLE;
                end else if (acc_step && r_phase != PH_IDLE) begin
                    if (i_status.half_done) begin
                        if (r_phase == PH_UPPER) begin
                            n_phase = PH_LAST;
                            n_state = ST_SETUP;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end else begin
                        n_state = ST_ADV0;
                    end
                end
            end
            ST_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = ST_SETUP;
                    n_phase = i_status.needs_split ? PH_UPPER : PH_LAST;
                end
            end
            ST_SETUP: n_state = ST_READY;
            ST_ADV0:  n_state = ST_CHASE;
            ST_CHASE: begin
                if (i_status.caught_up || i_status.chase_limit) begin
                    n_state = ST_READY;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.src = SRC_TOP;
        o_strobe = 1'b0;
        o_final = 1'b0;
        o_busy = !(r_state == ST_IDLE || r_state == ST_READY);
        case (r_state)
            ST_IDLE, ST_READY: begin
                o_cmd.load = acc_load;
                o_cmd.div_start = acc_load;
                if (acc_step && r_phase != PH_IDLE) begin
                    o_strobe = 1'b1;
                    o_final = i_status.half_done && r_phase == PH_LAST;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                if (r_phase == PH_LAST && !i_status.needs_split) begin
                    o_cmd.src = i_status.flat_bottom ? SRC_TOP : SRC_FLAT;
                end else if (r_phase == PH_LAST) begin
                    o_cmd.src = SRC_BOTTOM;
                end else begin
                    o_cmd.src = SRC_TOP;
                end
            end
            ST_ADV0: begin
                o_cmd.adv0 = 1'b1;
                o_cmd.count = 1'b1;
            end
            ST_CHASE: begin
                o_cmd.adv1 = !(i_status.caught_up || i_status.chase_limit);
            end
            default: ;
        endcase
    end

endmodule

[design/tsr_div.sv]
// restoring signed divider for the split point, one quotient bit per cycle
module tsr_div #(
    parameter int NUM_BITS = 26,
    parameter int DEN_BITS = 13
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [NUM_BITS-1:0] i_num,
    input  logic signed [DEN_BITS-1:0] i_den,
    output logic                       o_busy,
    output logic signed [NUM_BITS-1:0] o_quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_q;
    logic [DEN_BITS:0]   r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic                r_neg;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   shifted;

    assign shifted = {r_rem[DEN_BITS-1:0], r_q[NUM_BITS-1]};
    assign trial   = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_BITS'(NUM_BITS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num[NUM_BITS-1] ? -i_num : i_num;
            r_den <= i_den[DEN_BITS-1] ? -i_den : i_den;
            r_neg <= i_num[NUM_BITS-1] ^ i_den[DEN_BITS-1];
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            if (!trial[DEN_BITS]) begin
                r_rem <= trial;
                r_q   <= {r_q[NUM_BITS-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_q   <= {r_q[NUM_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_busy = i_start || (r_cnt != '0);
    assign o_quot = r_neg ? -r_q : r_q;

endmodule

[design/tsr_dp.sv]
// datapath: vertex sort, split product, edge walkers
module tsr_dp #(
    parameter int CB = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tsr_pkg::t_cmd        i_cmd,
    input  logic signed [CB-1:0] i_x_a,
    input  logic signed [CB-1:0] i_y_a,
    input  logic signed [CB-1:0] i_x_b,
    input  logic signed [CB-1:0] i_y_b,
    input  logic signed [CB-1:0] i_x_c,
    input  logic signed [CB-1:0] i_y_c,
    output tsr_pkg::t_status     o_status,
    output logic signed [CB-1:0] o_x0,
    output logic signed [CB-1:0] o_x1,
    output logic signed [CB-1:0] o_y0
);
    import tsr_pkg::*;

    localparam int DB = CB + 1;
    localparam int EB = CB + 4;
    localparam int NB = 2 * DB;
    localparam int GB = CB + 4;

    logic signed [CB-1:0] r_xa, r_ya, r_xb, r_yb, r_xc, r_yc;
    logic signed [CB-1:0] r_px [2];
    logic signed [CB-1:0] r_py [2];
    logic signed [EB-1:0] r_err [2];
    logic [DB-1:0]        r_maj [2];
    logic [DB-1:0]        r_min [2];
    logic signed [1:0]    r_sx [2];
    logic signed [1:0]    r_sy [2];
    logic                 r_swp [2];
    logic [DB-1:0]        r_cnt;
    logic [GB-1:0]        r_guard;
    logic signed [NB-1:0] r_prod;
    logic signed [DB-1:0] r_dy;
    logic                 r_div_go;

    logic signed [CB-1:0] s0x, s0y, s1x, s1y, s2x, s2y;
    logic signed [CB-1:0] t0x, t0y, t1x, t1y, t2x, t2y;
    logic signed [NB-1:0] quot;
    logic signed [CB-1:0] split_x;
    logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
    logic                 div_busy;

    // stable three-compare sort
    always_comb begin
        s0x = i_x_a; s0y = i_y_a; s1x = i_x_b; s1y = i_y_b;
        if (i_y_a > i_y_b) begin
            s0x = i_x_b; s0y = i_y_b; s1x = i_x_a; s1y = i_y_a;
        end
        t0x = s0x; t0y = s0y; t1x = s1x; t1y = s1y; t2x = i_x_c; t2y = i_y_c;
        if (s1y > i_y_c) begin
            t1x = i_x_c; t1y = i_y_c; t2x = s1x; t2y = s1y;
            if (s0y > i_y_c) begin
                t0x = i_x_c; t0y = i_y_c; t1x = s0x; t1y = s0y;
            end
        end
        s2x = t2x; s2y = t2y;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xa <= t0x; r_ya <= t0y;
            r_xb <= t1x; r_yb <= t1y;
            r_xc <= s2x; r_yc <= s2y;
        end
    end

    // product stage, then divider start
    always_ff @(posedge i_clk) begin
        r_prod <= (NB'(signed'(r_yb)) - NB'(signed'(r_ya)))
                * (NB'(signed'(r_xc)) - NB'(signed'(r_xa)));
        r_dy   <= DB'(signed'(r_yc)) - DB'(signed'(r_ya));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= i_cmd.load;
        end
    end

    logic r_div_wait;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_wait <= 1'b0;
        end else begin
            r_div_wait <= i_cmd.div_start || (r_div_wait && !r_div_go);
        end
    end

    logic r_div_go_q;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_go_q <= 1'b0;
        end else begin
            r_div_go_q <= r_div_go;
        end
    end

    tsr_div #(.NUM_BITS(NB), .DEN_BITS(DB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go_q),
        .i_num   (r_prod),
        .i_den   (r_dy),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    assign split_x = r_xa + CB'(quot);

    always_comb begin
        case (i_cmd.src)
            SRC_FLAT: begin
                ax = r_xc; ay = r_yc; bx = r_xa; by = r_ya; cx = r_xb; cy = r_yb;
            end
            SRC_BOTTOM: begin
                ax = r_xc; ay = r_yc; bx = r_xb; by = r_yb; cx = split_x; cy = r_yb;
            end
            default: begin
                ax = r_xa; ay = r_ya; bx = r_xb; by = r_yb;
                cx = (r_yb == r_yc) ? r_xc : split_x;
                cy = r_yb;
            end
        endcase
    end

    function automatic logic [DB-1:0] fabs(input logic signed [DB-1:0] v);
        fabs = v[DB-1] ? DB'(-v) : DB'(v);
    endfunction

    function automatic logic signed [1:0] fsgn(input logic signed [DB-1:0] v);
        fsgn = (v == '0) ? 2'sd0 : (v[DB-1] ? -2'sd1 : 2'sd1);
    endfunction

    logic signed [DB-1:0] ddx [2];
    logic signed [DB-1:0] ddy [2];
    logic [DB-1:0]        amx [2];
    logic [DB-1:0]        amy [2];

    always_comb begin
        ddx[0] = DB'(bx) - DB'(ax);
        ddy[0] = DB'(by) - DB'(ay);
        ddx[1] = DB'(cx) - DB'(ax);
        ddy[1] = DB'(cy) - DB'(ay);
        for (int k = 0; k < 2; k++) begin
            amx[k] = fabs(ddx[k]);
            amy[k] = fabs(ddy[k]);
        end
    end

    logic signed [CB-1:0] nx [2];
    logic signed [CB-1:0] ny [2];
    logic signed [EB-1:0] ne [2];
    logic                 adv [2];

    assign adv[0] = i_cmd.adv0;
    assign adv[1] = i_cmd.adv1;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            nx[k] = r_px[k];
            ny[k] = r_py[k];
            ne[k] = r_err[k];
            if (!r_err[k][EB-1] && r_maj[k] != '0) begin
                if (r_swp[k]) nx[k] = nx[k] + CB'(r_sx[k]);
                else          ny[k] = ny[k] + CB'(r_sy[k]);
                ne[k] = ne[k] - EB'({r_maj[k], 1'b0});
            end
            if (r_swp[k]) ny[k] = ny[k] + CB'(r_sy[k]);
            else          nx[k] = nx[k] + CB'(r_sx[k]);
            ne[k] = ne[k] + EB'({r_min[k], 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            if (i_cmd.setup) begin
                r_px[k] <= ax;
                r_py[k] <= ay;
                r_sx[k] <= fsgn(ddx[k]);
                r_sy[k] <= fsgn(ddy[k]);
                r_swp[k] <= amy[k] > amx[k];
                if (amy[k] > amx[k]) begin
                    r_maj[k] <= amy[k];
                    r_min[k] <= amx[k];
                    r_err[k] <= EB'({amx[k], 1'b0}) - EB'(amy[k]);
                end else begin
                    r_maj[k] <= amx[k];
                    r_min[k] <= amy[k];
                    r_err[k] <= EB'({amy[k], 1'b0}) - EB'(amx[k]);
                end
            end else if (adv[k]) begin
                r_px[k] <= nx[k];
                r_py[k] <= ny[k];
                r_err[k] <= ne[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.setup) begin
            r_cnt <= '0;
        end else if (i_cmd.count) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.adv0) begin
            r_guard <= '0;
        end else if (i_cmd.adv1) begin
            r_guard <= r_guard + 1'b1;
        end
    end

    assign o_status.div_busy    = div_busy || r_div_wait;
    assign o_status.needs_split = (r_yb != r_yc) && (r_ya != r_yb);
    assign o_status.flat_bottom = (r_yb == r_yc);
    assign o_status.half_done   = r_cnt >= r_maj[0];
    assign o_status.caught_up   = r_py[1] == r_py[0];
    assign o_status.chase_limit = r_guard[GB-1];

    assign o_x0 = r_px[0];
    assign o_x1 = r_px[1];
    assign o_y0 = r_py[0];

endmodule

[design/triangle_span_rasterizer.sv]
// triangle span rasterizer top level
// a load item's length is set by the serial split divider
// a step item gives its span in the accept cycle; unless its half is done, the
// ADV0 and CHASE states follow, busy high, till the chasing walker catches
// up or hits its guard; a half change runs SETUP; no result can be stalled
// synchronous active-low reset returns to idle with no triangle loaded
module triangle_span_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_action,
    input  logic signed [COORD_BITS-1:0] i_x_a,
    input  logic signed [COORD_BITS-1:0] i_y_a,
    input  logic signed [COORD_BITS-1:0] i_x_b,
    input  logic signed [COORD_BITS-1:0] i_y_b,
    input  logic signed [COORD_BITS-1:0] i_x_c,
    input  logic signed [COORD_BITS-1:0] i_y_c,
    output logic                         o_strobe,
    output logic signed [COORD_BITS-1:0] o_span_x_first,
    output logic signed [COORD_BITS-1:0] o_span_x_second,
    output logic signed [COORD_BITS-1:0] o_span_row,
    output logic                         o_final_span
);
    import tsr_pkg::*;

    t_cmd    cmd;
    t_status status;

    tsr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_final  (o_final_span)
    );

    tsr_dp #(.CB(COORD_BITS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_x_a    (i_x_a),
        .i_y_a    (i_y_a),
        .i_x_b    (i_x_b),
        .i_y_b    (i_y_b),
        .i_x_c    (i_x_c),
        .i_y_c    (i_y_c),
        .o_status (status),
        .o_x0     (o_span_x_first),
        .o_x1     (o_span_x_second),
        .o_y0     (o_span_row)
    );

    a_strobe_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (start && !busy && i_action))
        else $error("span without step item");

    a_final_needs_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_final_span |-> o_strobe)
        else $error("final flag without span");

    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_final_span && !status.half_done) |=> busy)
        else $error("walker advance not started");

endmodule
